// ===== rtl/core/tocp_pkg.sv =====
// Shared types and constants for the terminal output character processor.
package tocp_pkg;

   localparam logic [2:0] REG_RAW_MODE        = 3'd0;
   localparam logic [2:0] REG_EXPAND_TABS     = 3'd1;
   localparam logic [2:0] REG_UPPER_ONLY      = 3'd2;
   localparam logic [2:0] REG_NEWLINE_TO_CRLF = 3'd3;
   localparam logic [2:0] REG_VERTICAL_DELAY  = 3'd4;
   localparam logic [2:0] REG_NL_DELAY_KIND   = 3'd5;
   localparam logic [2:0] REG_TAB_DELAY_KIND  = 3'd6;
   localparam logic [2:0] REG_CR_DELAY_KIND   = 3'd7;

   localparam logic [6:0] CH_NUL    = 7'h00;
   localparam logic [6:0] CH_EOT    = 7'h04;
   localparam logic [6:0] CH_BS     = 7'h08;
   localparam logic [6:0] CH_TAB    = 7'h09;
   localparam logic [6:0] CH_LF     = 7'h0a;
   localparam logic [6:0] CH_VT     = 7'h0b;
   localparam logic [6:0] CH_FF     = 7'h0c;
   localparam logic [6:0] CH_CR     = 7'h0d;
   localparam logic [6:0] CH_SPACE  = 7'h20;
   localparam logic [6:0] CH_TILDE  = 7'h7e;
   localparam logic [6:0] CH_BSLASH = 7'h5c;
   localparam logic [6:0] CH_LOWER_A = 7'h61;
   localparam logic [6:0] CH_LOWER_Z = 7'h7a;
   localparam logic [6:0] CASE_OFFSET = 7'h20;

   localparam logic [1:0] NL_DELAY_COLUMN = 2'd1;
   localparam logic [1:0] NL_DELAY_FIXED  = 2'd2;
   localparam logic [1:0] NL_DELAY_PAD    = 2'd3;
   localparam logic [1:0] TAB_DELAY_COLUMN = 2'd1;
   localparam logic [1:0] CR_DELAY_SHORT  = 2'd1;
   localparam logic [1:0] CR_DELAY_LONG   = 2'd2;

   localparam logic [6:0] DELAY_VERTICAL = 7'd127;
   localparam logic [6:0] DELAY_NL_MIN   = 7'd6;
   localparam logic [6:0] DELAY_CR_SHORT = 7'd5;
   localparam logic [6:0] DELAY_CR_LONG  = 7'd10;
   localparam logic [3:0] TAB_DELAY_BASE = 4'd9;
   localparam logic [3:0] TAB_DELAY_MIN  = 4'd5;
   localparam logic [4:0] NL_DELAY_BIAS  = 5'd3;
   localparam logic [1:0] PAD_LAST       = 2'd3;

   // escape pairs: raised form, escaped form
   localparam int unsigned NUM_ESC = 5;
   localparam logic [6:0] ESC_FROM [NUM_ESC] = '{7'h7b, 7'h7d, 7'h7c, 7'h7e, 7'h60};
   localparam logic [6:0] ESC_TO   [NUM_ESC] = '{7'h28, 7'h29, 7'h21, 7'h5e, 7'h27};

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SPACE,
      ST_ESC,
      ST_CR,
      ST_CR_DLY,
      ST_CHAR,
      ST_PAD,
      ST_DLY
   } state_type;

   typedef enum logic [2:0] {
      SRC_SPACE,
      SRC_ESC,
      SRC_CR,
      SRC_CHAR,
      SRC_NUL,
      SRC_DELAY
   } src_type;

   typedef struct packed {
      logic    capture;
      logic    load;
      src_type src;
      logic    last;
   } cmd_type;

   typedef struct packed {
      logic slot_free;
      logic drop;
      logic tab_run;
      logic escape;
      logic crlf;
      logic space_last;
      logic put_pads;
      logic put_delay;
      logic pad_last;
   } stat_type;

endpackage

// ===== rtl/core/tocp_ctrl.sv =====
// Sequencer that steps through the output bytes of one character.
module tocp_ctrl import tocp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            priority if (stat.drop) state_in = ST_IDLE;
            else if (stat.tab_run) state_in = ST_SPACE;
            else if (stat.escape) state_in = ST_ESC;
            else if (stat.crlf) state_in = ST_CR;
            else state_in = ST_CHAR;
         end
         ST_SPACE: begin
            if (stat.slot_free && stat.space_last) state_in = ST_IDLE;
         end
         ST_ESC: begin
            if (stat.slot_free) state_in = ST_CHAR;
         end
         ST_CR: begin
            if (stat.slot_free) state_in = stat.put_delay ? ST_CR_DLY : ST_CHAR;
         end
         ST_CR_DLY: begin
            if (stat.slot_free) state_in = ST_CHAR;
         end
         ST_CHAR: begin
            if (stat.slot_free) begin
               priority if (stat.put_pads) state_in = ST_PAD;
               else if (stat.put_delay) state_in = ST_DLY;
               else state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            if (stat.slot_free && stat.pad_last) state_in = ST_IDLE;
         end
         ST_DLY: begin
            if (stat.slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.load    = 1'b0;
      cmd.src     = SRC_CHAR;
      cmd.last    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_DECIDE: begin
         end
         ST_SPACE: begin
            cmd.load = stat.slot_free;
            cmd.src  = SRC_SPACE;
            cmd.last = stat.space_last;
         end
         ST_ESC: begin
            cmd.load = stat.slot_free;
            cmd.src  = SRC_ESC;
         end
         ST_CR: begin
            cmd.load = stat.slot_free;
            cmd.src  = SRC_CR;
         end
         ST_CR_DLY: begin
            cmd.load = stat.slot_free;
            cmd.src  = SRC_DELAY;
         end
         ST_CHAR: begin
            cmd.load = stat.slot_free;
            cmd.src  = SRC_CHAR;
            cmd.last = !stat.put_pads && !stat.put_delay;
         end
         ST_PAD: begin
            cmd.load = stat.slot_free;
            cmd.src  = SRC_NUL;
            cmd.last = stat.pad_last;
         end
         ST_DLY: begin
            cmd.load = stat.slot_free;
            cmd.src  = SRC_DELAY;
            cmd.last = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/core/tocp_dp.sv =====
// Datapath: settings, column, captured character, delay and output register.
module tocp_dp import tocp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_data,
   input  logic [7:0] req_char_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run,
   input  cmd_type    cmd,
   output stat_type   stat
);

   logic       raw_mode_ff, expand_tabs_ff, upper_only_ff, crlf_ff, vert_delay_ff;
   logic [1:0] nl_kind_ff, tab_kind_ff, cr_kind_ff;
   logic [7:0] column_ff, column_in;
   logic [6:0] char_ff, char_in;
   logic       drop_ff, tab_run_ff, escape_ff, crlf_flag_ff;
   logic       drop_in, tab_run_in, escape_in;
   logic [6:0] delay_ff, delay_in;
   logic [1:0] pad_cnt_ff;
   logic       valid_ff;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff;
   logic [6:0] raw_char;
   logic [6:0] put_byte;
   logic [4:0] nl_col_delay;
   logic [3:0] tab_delay;
   logic       put_src;

   // settings
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_mode_ff    <= 1'b0;
         expand_tabs_ff <= 1'b0;
         upper_only_ff  <= 1'b0;
         crlf_ff        <= 1'b0;
         vert_delay_ff  <= 1'b0;
         nl_kind_ff     <= 2'd0;
         tab_kind_ff    <= 2'd0;
         cr_kind_ff     <= 2'd0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_RAW_MODE:        raw_mode_ff    <= csr_data[0];
            REG_EXPAND_TABS:     expand_tabs_ff <= csr_data[0];
            REG_UPPER_ONLY:      upper_only_ff  <= csr_data[0];
            REG_NEWLINE_TO_CRLF: crlf_ff        <= csr_data[0];
            REG_VERTICAL_DELAY:  vert_delay_ff  <= csr_data[0];
            REG_NL_DELAY_KIND:   nl_kind_ff     <= csr_data[1:0];
            REG_TAB_DELAY_KIND:  tab_kind_ff    <= csr_data[1:0];
            REG_CR_DELAY_KIND:   cr_kind_ff     <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // decode the incoming character
   always_comb begin
      raw_char   = req_char_in[6:0];
      char_in    = raw_char;
      escape_in  = 1'b0;
      drop_in    = (raw_char == CH_EOT) && !raw_mode_ff;
      tab_run_in = (raw_char == CH_TAB) && expand_tabs_ff;
      if (upper_only_ff) begin
         for (int i = 0; i < NUM_ESC; i++) begin
            if (raw_char == ESC_FROM[i]) begin
               escape_in = 1'b1;
               char_in   = ESC_TO[i];
            end
         end
         if (raw_char >= CH_LOWER_A && raw_char <= CH_LOWER_Z) begin
            char_in = raw_char - CASE_OFFSET;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         char_ff      <= char_in;
         drop_ff      <= drop_in;
         tab_run_ff   <= tab_run_in;
         escape_ff    <= escape_in;
         crlf_flag_ff <= (char_in == CH_LF) && crlf_ff;
      end
   end

   // byte being put and its effect on delay and column
   always_comb begin
      unique case (cmd.src)
         SRC_SPACE: put_byte = CH_SPACE;
         SRC_ESC:   put_byte = CH_BSLASH;
         SRC_CR:    put_byte = CH_CR;
         default:   put_byte = char_ff;
      endcase
      put_src = (cmd.src == SRC_SPACE) || (cmd.src == SRC_ESC) ||
                (cmd.src == SRC_CR) || (cmd.src == SRC_CHAR);

      nl_col_delay = {1'b0, column_ff[7:4]} + NL_DELAY_BIAS;
      tab_delay    = TAB_DELAY_BASE - {1'b0, column_ff[2:0]};

      delay_in  = '0;
      column_in = column_ff;
      if (put_byte >= CH_SPACE && put_byte <= CH_TILDE) begin
         column_in = column_ff + 8'd1;
      end else if (put_byte == CH_BS) begin
         if (column_ff != 8'd0) column_in = column_ff - 8'd1;
      end else if (put_byte == CH_LF) begin
         if (nl_kind_ff == NL_DELAY_COLUMN) begin
            if (column_ff != 8'd0) begin
               delay_in = ({2'b00, nl_col_delay} < DELAY_NL_MIN) ? DELAY_NL_MIN
                                                              : {2'b00, nl_col_delay};
            end
         end else if (nl_kind_ff == NL_DELAY_FIXED) begin
            delay_in = DELAY_NL_MIN;
         end
         column_in = 8'd0;
      end else if (put_byte == CH_TAB) begin
         if (tab_kind_ff == TAB_DELAY_COLUMN && tab_delay >= TAB_DELAY_MIN) begin
            delay_in = {3'b000, tab_delay};
         end
         column_in = (column_ff | 8'd7) + 8'd1;
      end else if (put_byte == CH_VT || put_byte == CH_FF) begin
         if (vert_delay_ff) delay_in = DELAY_VERTICAL;
      end else if (put_byte == CH_CR) begin
         if (cr_kind_ff == CR_DELAY_SHORT) delay_in = DELAY_CR_SHORT;
         else if (cr_kind_ff == CR_DELAY_LONG) delay_in = DELAY_CR_LONG;
         column_in = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= 8'd0;
      end else if (cmd.load && put_src) begin
         column_ff <= column_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && put_src) delay_ff <= delay_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pad_cnt_ff <= 2'd0;
      end else if (cmd.load && cmd.src == SRC_NUL) begin
         pad_cnt_ff <= pad_cnt_ff + 2'd1;
      end
   end

   // output register
   always_comb begin
      unique case (cmd.src)
         SRC_NUL:   byte_in = {1'b0, CH_NUL};
         SRC_DELAY: byte_in = {1'b1, delay_ff};
         default:   byte_in = {1'b0, put_byte};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         byte_ff <= byte_in;
         last_ff <= cmd.last;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_last_of_run = last_ff;

   always_comb begin
      stat.slot_free  = !valid_ff || rsp_ready;
      stat.drop       = drop_ff;
      stat.tab_run    = tab_run_ff;
      stat.escape     = escape_ff;
      stat.crlf       = crlf_flag_ff;
      stat.space_last = (column_ff[2:0] == 3'b111);
      stat.put_pads   = (put_byte == CH_LF) && (nl_kind_ff == NL_DELAY_PAD);
      stat.put_delay  = (delay_in != 7'd0);
      stat.pad_last   = (pad_cnt_ff == PAD_LAST);
   end

endmodule

// ===== rtl/core/tty_output_char_processor.sv =====
// Top level of the terminal output character processor.
// One character is taken per req_ beat and turned into a run of 0 to 8 output bytes on the
// rsp_ channel, the last flagged by rsp_last_of_run; a byte with bit 7 set is a delay of its
// low 7 bits in ticks. The sequencer accepts a character in its idle state and picks its path
// in a decide state, then puts out one byte per cycle while rsp_ready holds. The last byte waits
// in the output register while the next character is accepted. Settings are written on the
// csr_ port, index 0..7, always ready.
module tty_output_char_processor import tocp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   tocp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tocp_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_char_in     (req_char_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .cmd             (cmd),
      .stat            (stat)
   );

endmodule
